// ----- sv/zop_pkg.sv -----
// ----------------------------------------------------------------------------
// zop_pkg: shared types and constants of the zone occupancy predictor
// Function codes, Q1.15 constants, weights and the stage control struct.
// ----------------------------------------------------------------------------
package zop_pkg;

  typedef enum logic [0:0] {
    FUNC_OBSERVE = 1'b0,
    FUNC_WRITE   = 1'b1
  } zop_func_t;

  // Control bits of the item held in the compute stage.
  typedef struct packed {
    logic accepted;
    logic occupied;
  } zop_ctl_t;

  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] STEP_Q15   = 16'd8192;
  localparam logic [15:0] W_AVG      = 16'd11469;
  localparam logic [15:0] W_HIST     = 16'd9830;
  localparam logic [15:0] W_NEIGH    = 16'd6554;
  localparam logic [15:0] W_TREND    = 16'd3277;
  localparam logic [31:0] OCC_TERM   = 32'd4915 << 15;
  localparam logic [31:0] ROUND_HALF = 32'd16384;
  localparam int unsigned CONF_BASE  = 14746;
  localparam int unsigned CONF_SPAN  = 18022;

  // Default history profile by hour band, and the per-zone bias.
  localparam logic [15:0] PROF_MORNING = 16'd20316;
  localparam logic [15:0] PROF_DAY     = 16'd9830;
  localparam logic [15:0] PROF_EVENING = 16'd23593;
  localparam logic [15:0] PROF_LATE    = 16'd11469;
  localparam logic [15:0] PROF_NIGHT   = 16'd3932;
  localparam logic [15:0] BIAS_UP      = 16'd1638;
  localparam logic [15:0] BIAS_DOWN    = 16'd1311;

  localparam int unsigned HOURS = 24;

endpackage

// ----- sv/zop_in_if.sv -----
// ----------------------------------------------------------------------------
// zop_in_if: input channel of the zone occupancy predictor
// Valid/ready channel carrying one observe or history write item.
// ----------------------------------------------------------------------------
interface zop_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  func;
  logic [7:0]  zone_index;
  logic        occupied;
  logic [7:0]  hour_of_day;
  logic [15:0] history_value;

  modport source (
    output valid, func, zone_index, occupied, hour_of_day, history_value,
    input  ready
  );
  modport sink (
    input  valid, func, zone_index, occupied, hour_of_day, history_value,
    output ready
  );
endinterface

// ----- sv/zop_out_if.sv -----
// ----------------------------------------------------------------------------
// zop_out_if: result channel of the zone occupancy predictor
// Valid/ready channel carrying one prediction result.
// ----------------------------------------------------------------------------
interface zop_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] probability;
  logic [15:0] confidence;

  modport source (
    output valid, accepted, probability, confidence,
    input  ready
  );
  modport sink (
    input  valid, accepted, probability, confidence,
    output ready
  );
endinterface

// ----- sv/zop_hist.sv -----
// ----------------------------------------------------------------------------
// zop_hist: hour/zone history memory
// One write and one registered read per cycle, filled with the default
// hour profile by a sweep after reset.
// ----------------------------------------------------------------------------
module zop_hist #(
  parameter int MAX_ZONES = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  logic                                        rd_en,
  input  logic [7:0]                                  hour_raw,
  input  logic [((MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1)-1:0] zone,
  input  logic [15:0]                                 wr_value,
  output logic [15:0]                                 rd_data,
  output logic                                        init_done
);

  localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int DEPTH = zop_pkg::HOURS * MAX_ZONES;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q;

  logic [AW-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [4:0]    sweep_hour_r, sweep_hour_nxt;
  logic [ZW-1:0] sweep_zone_r, sweep_zone_nxt;
  logic [1:0]    sweep_mod3_r, sweep_mod3_nxt;
  logic          init_done_r, init_done_nxt;

  logic [4:0]    hour;
  logic [AW-1:0] addr;
  logic [15:0]   wr_sat;
  logic [15:0]   dflt_value;
  logic [15:0]   prof;

  // Hour mod 24 as 8*((h>>3) mod 3) + h[2:0]; the mod 3 sums base-4 digits.
  function automatic logic [4:0] hour_mod24(input logic [7:0] h);
    logic [2:0] s;
    s = {1'b0, h[4:3]} + {1'b0, h[6:5]} + {2'b00, h[7]};
    if (s >= 3'd6) begin
      s = s - 3'd6;
    end else if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return {s[1:0], h[2:0]};
  endfunction

  always_comb begin
    hour   = hour_mod24(hour_raw);
    addr   = AW'(hour) * AW'(MAX_ZONES) + AW'(zone);
    wr_sat = (wr_value > zop_pkg::ONE_Q15) ? zop_pkg::ONE_Q15 : wr_value;
  end

  always_comb begin
    priority if (sweep_hour_r >= 5'd6 && sweep_hour_r <= 5'd8) begin
      prof = zop_pkg::PROF_MORNING;
    end else if (sweep_hour_r >= 5'd9 && sweep_hour_r <= 5'd16) begin
      prof = zop_pkg::PROF_DAY;
    end else if (sweep_hour_r >= 5'd17 && sweep_hour_r <= 5'd21) begin
      prof = zop_pkg::PROF_EVENING;
    end else if (sweep_hour_r >= 5'd22) begin
      prof = zop_pkg::PROF_LATE;
    end else begin
      prof = zop_pkg::PROF_NIGHT;
    end
    unique case (sweep_mod3_r)
      2'd0:    dflt_value = prof + zop_pkg::BIAS_UP;
      2'd2:    dflt_value = prof - zop_pkg::BIAS_DOWN;
      default: dflt_value = prof;
    endcase
  end

  always_comb begin
    sweep_addr_nxt = sweep_addr_r;
    sweep_hour_nxt = sweep_hour_r;
    sweep_zone_nxt = sweep_zone_r;
    sweep_mod3_nxt = sweep_mod3_r;
    init_done_nxt  = init_done_r;
    if (!init_done_r) begin
      sweep_addr_nxt = sweep_addr_r + AW'(1);
      if (sweep_zone_r == ZW'(MAX_ZONES - 1)) begin
        sweep_zone_nxt = '0;
        sweep_mod3_nxt = 2'd0;
        sweep_hour_nxt = sweep_hour_r + 5'd1;
        if (sweep_hour_r == 5'(zop_pkg::HOURS - 1)) begin
          init_done_nxt = 1'b1;
        end
      end else begin
        sweep_zone_nxt = sweep_zone_r + ZW'(1);
        sweep_mod3_nxt = (sweep_mod3_r == 2'd2) ? 2'd0 : sweep_mod3_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      sweep_hour_r <= '0;
      sweep_zone_r <= '0;
      sweep_mod3_r <= '0;
      init_done_r  <= 1'b0;
    end else begin
      sweep_addr_r <= sweep_addr_nxt;
      sweep_hour_r <= sweep_hour_nxt;
      sweep_zone_r <= sweep_zone_nxt;
      sweep_mod3_r <= sweep_mod3_nxt;
      init_done_r  <= init_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[sweep_addr_r] <= dflt_value;
    end else if (wr_en) begin
      mem[addr] <= wr_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[addr];
    end
  end

  assign rd_data   = rd_q;
  assign init_done = init_done_r;

endmodule

// ----- sv/zop_zone.sv -----
// ----------------------------------------------------------------------------
// zop_zone: per-zone average and sample count store
// Registered reads of the zone and its two neighbors, one write-back per
// cycle, with valid bits for the zero reset and a bypass of the last write.
// ----------------------------------------------------------------------------
module zop_zone #(
  parameter int MAX_ZONES = 16,
  parameter int SW        = 5
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        rd_en,
  input  logic                                        rd_lo_en,
  input  logic                                        rd_hi_en,
  input  logic [((MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1)-1:0] rd_zone,
  input  logic                                        wr_en,
  input  logic [15:0]                                 wr_avg,
  input  logic [SW-1:0]                               wr_samples,
  output logic [15:0]                                 cur_avg,
  output logic [SW-1:0]                               cur_samples,
  output logic [15:0]                                 lo_avg,
  output logic [15:0]                                 hi_avg
);

  localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

  // Port A holds average and count (zone and lower neighbor reads),
  // port B a copy of the average for the upper neighbor read.
  logic [SW+15:0] mem_a [MAX_ZONES];
  logic [15:0]    mem_b [MAX_ZONES];
  logic [MAX_ZONES-1:0] vld_r;

  logic [ZW-1:0]  lo_zone, hi_zone;
  logic [ZW-1:0]  cur_idx_q, lo_idx_q, hi_idx_q;
  logic [SW+15:0] cur_q, lo_q;
  logic [15:0]    hi_q;
  logic           cur_vld_q, lo_vld_q, hi_vld_q;
  logic           lo_ok_q, hi_ok_q;

  logic           fwd_valid_r;
  logic [ZW-1:0]  fwd_idx_r;
  logic [15:0]    fwd_avg_r;
  logic [SW-1:0]  fwd_samples_r;

  logic           hit_cur, hit_lo, hit_hi;

  assign lo_zone = rd_zone - ZW'(1);
  assign hi_zone = rd_zone + ZW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[cur_idx_q] <= {wr_samples, wr_avg};
      mem_b[cur_idx_q] <= wr_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_q     <= mem_a[rd_zone];
      cur_vld_q <= vld_r[rd_zone];
      cur_idx_q <= rd_zone;
      lo_ok_q   <= rd_lo_en;
      hi_ok_q   <= rd_hi_en;
    end
    if (rd_lo_en) begin
      lo_q     <= mem_a[lo_zone];
      lo_vld_q <= vld_r[lo_zone];
      lo_idx_q <= lo_zone;
    end
    if (rd_hi_en) begin
      hi_q     <= mem_b[hi_zone];
      hi_vld_q <= vld_r[hi_zone];
      hi_idx_q <= hi_zone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      vld_r[cur_idx_q] <= 1'b1;
      fwd_valid_r      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx_r     <= cur_idx_q;
      fwd_avg_r     <= wr_avg;
      fwd_samples_r <= wr_samples;
    end
  end

  // The write at the edge that loaded the read registers is not in the read
  // data, so the most recent write wins wherever its zone matches.
  always_comb begin
    hit_cur = fwd_valid_r && (fwd_idx_r == cur_idx_q);
    hit_lo  = fwd_valid_r && (fwd_idx_r == lo_idx_q);
    hit_hi  = fwd_valid_r && (fwd_idx_r == hi_idx_q);

    if (hit_cur) begin
      cur_avg     = fwd_avg_r;
      cur_samples = fwd_samples_r;
    end else if (cur_vld_q) begin
      cur_avg     = cur_q[15:0];
      cur_samples = cur_q[SW+15:16];
    end else begin
      cur_avg     = '0;
      cur_samples = '0;
    end

    if (!lo_ok_q) begin
      lo_avg = '0;
    end else if (hit_lo) begin
      lo_avg = fwd_avg_r;
    end else if (lo_vld_q) begin
      lo_avg = lo_q[15:0];
    end else begin
      lo_avg = '0;
    end

    if (!hi_ok_q) begin
      hi_avg = '0;
    end else if (hit_hi) begin
      hi_avg = fwd_avg_r;
    end else if (hi_vld_q) begin
      hi_avg = hi_q;
    end else begin
      hi_avg = '0;
    end
  end

endmodule

// ----- sv/zop_calc.sv -----
// ----------------------------------------------------------------------------
// zop_calc: prediction arithmetic of one observe item
// Average update, sample count, weighted probability sum and confidence.
// ----------------------------------------------------------------------------
module zop_calc #(
  parameter int SAMPLE_FULL = 20,
  parameter int SW          = 5
) (
  input  zop_pkg::zop_ctl_t ctl,
  input  logic [15:0]       old_avg,
  input  logic [SW-1:0]     old_samples,
  input  logic [15:0]       hist,
  input  logic [15:0]       lo_avg,
  input  logic [15:0]       hi_avg,
  output logic [15:0]       new_avg,
  output logic [SW-1:0]     new_samples,
  output logic              accepted,
  output logic [15:0]       probability,
  output logic [15:0]       confidence
);

  logic [15:0] conf_tab [SAMPLE_FULL+1];

  // Confidence for each sample count, worked out at elaboration.
  for (genvar k = 0; k <= SAMPLE_FULL; k++) begin : g_conf
    localparam int unsigned CV = zop_pkg::CONF_BASE
                               + (zop_pkg::CONF_SPAN * k + SAMPLE_FULL / 2) / SAMPLE_FULL;
    assign conf_tab[k] = 16'(CV);
  end

  logic [16:0] avg_raw;
  logic [15:0] neigh;
  logic [15:0] trend;
  logic [31:0] sum;
  logic [16:0] prob_raw;

  always_comb begin
    avg_raw = {1'b0, old_avg} - {3'b000, old_avg[15:2]}
            + (ctl.occupied ? {1'b0, zop_pkg::STEP_Q15} : 17'd0);
    new_avg = (avg_raw > {1'b0, zop_pkg::ONE_Q15}) ? zop_pkg::ONE_Q15 : avg_raw[15:0];

    new_samples = (old_samples < SW'(SAMPLE_FULL)) ? old_samples + SW'(1) : old_samples;

    neigh = (lo_avg > hi_avg) ? lo_avg : hi_avg;
    trend = (new_avg > old_avg) ? new_avg - old_avg : 16'd0;

    sum = {16'd0, zop_pkg::W_AVG}   * {16'd0, new_avg}
        + {16'd0, zop_pkg::W_HIST}  * {16'd0, hist}
        + {16'd0, zop_pkg::W_NEIGH} * {16'd0, neigh}
        + {16'd0, zop_pkg::W_TREND} * {16'd0, trend}
        + (ctl.occupied ? zop_pkg::OCC_TERM : 32'd0)
        + zop_pkg::ROUND_HALF;
    prob_raw = sum[31:15];

    accepted = ctl.accepted;
    if (ctl.accepted) begin
      probability = (prob_raw > {1'b0, zop_pkg::ONE_Q15}) ? zop_pkg::ONE_Q15
                                                          : prob_raw[15:0];
      confidence  = conf_tab[new_samples];
    end else begin
      probability = '0;
      confidence  = '0;
    end
  end

endmodule

// ----- sv/zone_occupancy_predictor_top.sv -----
// ----------------------------------------------------------------------------
// zone_occupancy_predictor_top: per-zone occupancy predictor
// Keeps a running occupancy average per zone and predicts a Q1.15
// occupancy probability and confidence from it and an hour/zone history.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (valid/ready). An observe item yields one result on
// out_ch; a history write item updates the hour/zone table and yields none.
// The user must set the zone count through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it. One item is taken
// every cycle while out_ch accepts results. The memories are read into
// registers at the transfer of an item; the arithmetic runs from those
// registers and lands in the output register. The zone store update, with a
// bypass of the last write-back, is what sets that rate.
// After reset, in_ch.ready stays low while the history memory is filled with
// the default hour profile, one entry per hour and zone; zone averages and
// counts start at zero.
// When out_ch stalls, one finished result waits in the output register and
// one more item is held in the compute stage; then in_ch.ready drops.
// ----------------------------------------------------------------------------
module zone_occupancy_predictor_top #(
  parameter int MAX_ZONES   = 16,
  parameter int SAMPLE_FULL = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  zop_in_if.sink      in_ch,
  zop_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int SW = $clog2(SAMPLE_FULL + 1);

  logic [4:0]  active_r;

  logic        init_done;
  logic        in_fire, obs_fire;
  logic        is_write;
  logic [8:0]  zone9, zone9_up;
  logic        zone_ok, has_lo, has_hi;
  logic [ZW-1:0] zone;

  logic        s1_valid_r, s1_valid_nxt;
  zop_pkg::zop_ctl_t s1_ctl_r;
  logic        s1_adv;

  logic        out_valid_r, out_valid_nxt;
  logic        out_accepted_r;
  logic [15:0] out_prob_r, out_conf_r;

  logic [15:0]   hist_rd;
  logic [15:0]   cur_avg, lo_avg, hi_avg;
  logic [SW-1:0] cur_samples;
  logic [15:0]   new_avg;
  logic [SW-1:0] new_samples;
  logic          res_accepted;
  logic [15:0]   res_prob, res_conf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 5'd16;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_comb begin
    zone9    = {1'b0, in_ch.zone_index};
    zone9_up = zone9 + 9'd1;
    zone_ok  = (zone9 < {4'd0, active_r}) && (zone9 < 9'(MAX_ZONES));
    has_lo   = (in_ch.zone_index != 8'd0);
    has_hi   = (zone9_up < {4'd0, active_r}) && (zone9_up < 9'(MAX_ZONES));
    zone     = in_ch.zone_index[ZW-1:0];
    is_write = (in_ch.func == zop_pkg::FUNC_WRITE);
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = init_done && (!s1_valid_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign obs_fire    = in_fire && !is_write;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (obs_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (obs_fire) begin
      s1_ctl_r.accepted <= zone_ok;
      s1_ctl_r.occupied <= in_ch.occupied;
    end
    if (s1_adv) begin
      out_accepted_r <= res_accepted;
      out_prob_r     <= res_prob;
      out_conf_r     <= res_conf;
    end
  end

  zop_hist #(
    .MAX_ZONES (MAX_ZONES)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_fire && is_write && zone_ok),
    .rd_en     (obs_fire && zone_ok),
    .hour_raw  (in_ch.hour_of_day),
    .zone      (zone),
    .wr_value  (in_ch.history_value),
    .rd_data   (hist_rd),
    .init_done (init_done)
  );

  zop_zone #(
    .MAX_ZONES (MAX_ZONES),
    .SW        (SW)
  ) u_zone (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (obs_fire && zone_ok),
    .rd_lo_en    (obs_fire && zone_ok && has_lo),
    .rd_hi_en    (obs_fire && zone_ok && has_hi),
    .rd_zone     (zone),
    .wr_en       (s1_adv && s1_ctl_r.accepted),
    .wr_avg      (new_avg),
    .wr_samples  (new_samples),
    .cur_avg     (cur_avg),
    .cur_samples (cur_samples),
    .lo_avg      (lo_avg),
    .hi_avg      (hi_avg)
  );

  zop_calc #(
    .SAMPLE_FULL (SAMPLE_FULL),
    .SW          (SW)
  ) u_calc (
    .ctl         (s1_ctl_r),
    .old_avg     (cur_avg),
    .old_samples (cur_samples),
    .hist        (hist_rd),
    .lo_avg      (lo_avg),
    .hi_avg      (hi_avg),
    .new_avg     (new_avg),
    .new_samples (new_samples),
    .accepted    (res_accepted),
    .probability (res_prob),
    .confidence  (res_conf)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_accepted_r;
  assign out_ch.probability = out_prob_r;
  assign out_ch.confidence  = out_conf_r;

endmodule

// ----- dv/zop_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zop_checker: prediction and result check for the zone occupancy predictor
// Watches the item and result channels and the zone count register, keeps
// its own copy of the zone averages, sample counts and hour/zone history,
// and compares every result transfer field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module zop_checker #(
  parameter int MAX_ZONES   = 16,
  parameter int SAMPLE_FULL = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  zop_in_if           in_mon,
  zop_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output int unsigned fail_count,
  output int unsigned pending_results
);

  typedef struct packed {
    logic        accepted;
    logic [15:0] probability;
    logic [15:0] confidence;
  } zop_result_t;

  logic [4:0]  zone_count_reg;
  logic [15:0] zone_avg [MAX_ZONES];
  int unsigned zone_hits [MAX_ZONES];
  logic [15:0] hour_history [zop_pkg::HOURS * MAX_ZONES];
  zop_result_t predictions [$];

  function automatic logic [15:0] default_history(int unsigned hr, int unsigned zn);
    logic [15:0] base;
    if (hr >= 6 && hr <= 8) base = zop_pkg::PROF_MORNING;
    else if (hr >= 9 && hr <= 16) base = zop_pkg::PROF_DAY;
    else if (hr >= 17 && hr <= 21) base = zop_pkg::PROF_EVENING;
    else if (hr >= 22) base = zop_pkg::PROF_LATE;
    else base = zop_pkg::PROF_NIGHT;
    if (zn % 3 == 0) base = base + zop_pkg::BIAS_UP;
    else if (zn % 3 == 2) base = base - zop_pkg::BIAS_DOWN;
    return base;
  endfunction

  task automatic clear_state();
    zone_count_reg = 5'd16;
    for (int z = 0; z < MAX_ZONES; z++) begin
      zone_avg[z]  = '0;
      zone_hits[z] = 0;
      for (int h = 0; h < zop_pkg::HOURS; h++) begin
        hour_history[h * MAX_ZONES + z] = default_history(h, z);
      end
    end
    predictions.delete();
  endtask

  // Applies one accepted item to the shadow state and queues the result of an observe item.
  task automatic take_item(zop_pkg::zop_func_t fn, logic [7:0] zone, logic occ,
                           logic [7:0] hour_raw, logic [15:0] hval);
    int unsigned lim, slot, n, conf;
    logic [16:0] prev, next, trend;
    logic [15:0] nb;
    logic [63:0] acc, prob;
    zop_result_t res;
    lim  = (zone_count_reg < 5'd16) ? 32'(zone_count_reg) : 32'(MAX_ZONES);
    if (lim > MAX_ZONES) lim = MAX_ZONES;
    slot = (32'(hour_raw) % zop_pkg::HOURS) * MAX_ZONES + 32'(zone);
    if (fn == zop_pkg::FUNC_WRITE) begin
      if (32'(zone) < lim) begin
        hour_history[slot] = (hval > zop_pkg::ONE_Q15) ? zop_pkg::ONE_Q15 : hval;
      end
    end else if (32'(zone) >= lim) begin
      predictions.push_back('0);
    end else begin
      prev = {1'b0, zone_avg[zone]};
      next = prev - (prev >> 2) + (occ ? {1'b0, zop_pkg::STEP_Q15} : 17'd0);
      if (next > {1'b0, zop_pkg::ONE_Q15}) next = {1'b0, zop_pkg::ONE_Q15};
      zone_avg[zone] = next[15:0];
      if (zone_hits[zone] < SAMPLE_FULL) zone_hits[zone]++;
      // Neighbors are read after this zone's own update.
      nb = '0;
      if (zone > 0 && zone_avg[zone - 1] > nb) nb = zone_avg[zone - 1];
      if (32'(zone) + 1 < lim && zone_avg[zone + 1] > nb) nb = zone_avg[zone + 1];
      trend = (next > prev) ? next - prev : 17'd0;
      acc = 64'(zop_pkg::W_AVG) * 64'(next)
          + 64'(zop_pkg::W_HIST) * 64'(hour_history[slot])
          + 64'(zop_pkg::W_NEIGH) * 64'(nb)
          + (occ ? 64'(zop_pkg::OCC_TERM) : 64'd0)
          + 64'(zop_pkg::W_TREND) * 64'(trend);
      prob = (acc + 64'(zop_pkg::ROUND_HALF)) >> 15;
      if (prob > 64'(zop_pkg::ONE_Q15)) prob = 64'(zop_pkg::ONE_Q15);
      n = (zone_hits[zone] > SAMPLE_FULL) ? SAMPLE_FULL : zone_hits[zone];
      conf = zop_pkg::CONF_BASE + (zop_pkg::CONF_SPAN * n + SAMPLE_FULL / 2) / SAMPLE_FULL;
      if (conf > 32'(zop_pkg::ONE_Q15)) conf = 32'(zop_pkg::ONE_Q15);
      res.accepted    = 1'b1;
      res.probability = prob[15:0];
      res.confidence  = conf[15:0];
      predictions.push_back(res);
    end
  endtask

  task automatic check_result();
    zop_result_t want;
    if (predictions.size() == 0) begin
      fail_count++;
      $error("result transfer with no prediction waiting");
    end else begin
      want = predictions.pop_front();
      if (out_mon.accepted !== want.accepted) begin
        fail_count++;
        $error("accepted: expected %0d, got %0d", want.accepted, out_mon.accepted);
      end
      if (out_mon.probability !== want.probability) begin
        fail_count++;
        $error("probability: expected %0d, got %0d", want.probability, out_mon.probability);
      end
      if (out_mon.confidence !== want.confidence) begin
        fail_count++;
        $error("confidence: expected %0d, got %0d", want.confidence, out_mon.confidence);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if ($isunknown(in_mon.ready) || $isunknown(out_mon.valid)) begin
        fail_count++;
        $error("handshake unknown: in ready %b, out valid %b", in_mon.ready, out_mon.valid);
      end
      if (cfg_we) zone_count_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        take_item(zop_pkg::zop_func_t'(in_mon.func), in_mon.zone_index, in_mon.occupied,
                  in_mon.hour_of_day, in_mon.history_value);
      end
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending_results = predictions.size();
  end

endmodule

// ----- dv/tb_zone_occupancy_predictor_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zone_occupancy_predictor_top: testbench of the zone occupancy predictor
// Drives directed and random observe and history write items under several
// zone counts, with random gaps on both channels, a long result stall and
// drain pauses. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_zone_occupancy_predictor_top;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned PHASES      = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count;
  bit          tx_burst;
  bit          rx_burst;
  bit          rx_hold;

  zop_in_if  in_ch ();
  zop_out_if out_ch ();

  zone_occupancy_predictor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  zop_checker u_predict (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_zone_occupancy_predictor_top: done, errors");
      $finish;
    end
  end

  // Offers one item after a random gap and returns at the falling edge after its transfer.
  task automatic send(zop_pkg::zop_func_t fn, logic [7:0] zone, logic occ, logic [7:0] hour,
                      logic [15:0] hval);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.func          = fn;
    in_ch.zone_index    = zone;
    in_ch.occupied      = occ;
    in_ch.hour_of_day   = hour;
    in_ch.history_value = hval;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // Writes that cause no result may still be in flight once the queue is empty.
  task automatic set_zone_count(logic [4:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Result side: random stalls, stretches with none, and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        rx_hold = 1'b0;
      end
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    logic [4:0]  zone_settings [PHASES];
    logic [4:0]  setting;
    int unsigned lim, counted, quota, occ_bias, pick;
    zop_pkg::zop_func_t fn;
    logic [7:0]  zone;
    logic [7:0]  hour;
    logic [15:0] hval;
    zone_settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd3, 5'd17, 5'd16};
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = zop_pkg::FUNC_OBSERVE;
    in_ch.zone_index    = '0;
    in_ch.occupied      = 1'b0;
    in_ch.hour_of_day   = '0;
    in_ch.history_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items under the reset zone count of 16.
    send(zop_pkg::FUNC_OBSERVE, 8'd0,   1'b1, 8'd0,   16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd15,  1'b1, 8'd23,  16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd1,   1'b0, 8'd255, 16'hFFFF);
    send(zop_pkg::FUNC_OBSERVE, 8'd14,  1'b1, 8'd24,  16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd16,  1'b1, 8'd7,   16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd255, 1'b1, 8'd255, 16'hFFFF);
    send(zop_pkg::FUNC_WRITE,   8'd3,   1'b0, 8'd30,  16'hFFFF);
    send(zop_pkg::FUNC_OBSERVE, 8'd3,   1'b1, 8'd6,   16'd0);
    send(zop_pkg::FUNC_WRITE,   8'd2,   1'b1, 8'd200, 16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd2,   1'b0, 8'd200, 16'd0);
    send(zop_pkg::FUNC_WRITE,   8'd200, 1'b0, 8'd5,   16'd1234);
    send(zop_pkg::FUNC_WRITE,   8'd15,  1'b0, 8'd23,  zop_pkg::ONE_Q15);
    send(zop_pkg::FUNC_OBSERVE, 8'd15,  1'b1, 8'd23,  16'd0);
    send(zop_pkg::FUNC_WRITE,   8'd0,   1'b0, 8'd0,   zop_pkg::ONE_Q15 + 16'd1);
    send(zop_pkg::FUNC_OBSERVE, 8'd0,   1'b0, 8'd0,   16'd0);
    repeat (6) send(zop_pkg::FUNC_OBSERVE, 8'd1, 1'b1, 8'd8, 16'd0);
    send(zop_pkg::FUNC_OBSERVE, 8'd1,   1'b0, 8'd17,  16'd0);

    for (int p = 0; p < PHASES; p++) begin
      setting = zone_settings[p];
      if (p == 5) setting = 5'($urandom_range(3, 15));
      set_zone_count(setting);
      lim      = (setting < 5'd16) ? 32'(setting) : 16;
      quota    = (setting == 5'd0) ? 40 : 118;
      occ_bias = $urandom_range(15, 90);
      counted  = 0;
      while (counted < quota) begin
        if (p == 2 && counted == 30) rx_hold = 1'b1;
        if (p == 4 && counted == 60) drain();
        fn   = ($urandom_range(0, 4) == 0) ? zop_pkg::FUNC_WRITE : zop_pkg::FUNC_OBSERVE;
        pick = $urandom_range(0, 9);
        if (lim != 0 && pick < 8) zone = 8'($urandom_range(0, lim - 1));
        else if (pick == 8) zone = 8'(lim + $urandom_range(0, 2));
        else zone = 8'($urandom_range(0, 255));
        hour = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 23));
        case ($urandom_range(0, 3))
          0:       hval = 16'($urandom_range(0, 65535));
          1:       hval = zop_pkg::ONE_Q15;
          default: hval = 16'($urandom_range(0, 32768));
        endcase
        send(fn, zone, $urandom_range(0, 99) < occ_bias, hour, hval);
        // Writes outside the zone range are dropped by the block.
        if (!(fn == zop_pkg::FUNC_WRITE && 32'(zone) >= lim)) counted++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb_zone_occupancy_predictor_top: done, clean");
    else $display("tb_zone_occupancy_predictor_top: done, errors");
    $finish;
  end

endmodule

// ----- zone_occupancy_predictor_top.f -----
sv/zop_pkg.sv
sv/zop_in_if.sv
sv/zop_out_if.sv
sv/zop_hist.sv
sv/zop_zone.sv
sv/zop_calc.sv
sv/zone_occupancy_predictor_top.sv
dv/zop_checker.sv
dv/tb_zone_occupancy_predictor_top.sv
